FILE: rtl/swr_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the stop-and-wait packet receiver.
// No dependencies; imported by every module of the block.
package swr_pkg;

   // Packet framing
   localparam int HEADER_BYTES     = 7;
   localparam int MAX_PACKET_BYTES = 16384;
   localparam int POS_W            = 15;   // holds 0 .. MAX_PACKET_BYTES
   localparam int HDR_W            = 6;    // stored header bytes 1 to 6

   // Header byte slots
   localparam int HDR_LAST   = 0;
   localparam int HDR_SEQ_HI = 1;
   localparam int HDR_SEQ_LO = 2;
   localparam int HDR_LEN_HI = 3;
   localparam int HDR_LEN_LO = 4;
   localparam int HDR_TYPE   = 5;

   // Reply codes and marks
   localparam logic [7:0] CODE_ACK  = 8'h25;
   localparam logic [7:0] CODE_NAK  = 8'h5E;
   localparam logic [7:0] LAST_MARK = 8'h24;
   localparam logic [7:0] SEQ_REJECT = 8'hFF;
   localparam logic [7:0] SUM_GOOD  = 8'hFF;
   localparam logic [7:0] LAST_LO_RESET = 8'hFF;

   // Result word kinds
   localparam logic ITEM_PAYLOAD = 1'b0;
   localparam logic ITEM_VERDICT = 1'b1;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   // One classified input word, as handed from front to back
   typedef struct packed {
      logic       has_payload;
      logic [7:0] payload_byte;
      logic       has_verdict;
      logic [7:0] reply_code;
      logic [7:0] reply_seq_high;
      logic [7:0] reply_seq_low;
      logic       accepted;
      logic       transfer_done;
   } rec_type;

endpackage

FILE: rtl/swr_front.sv
`timescale 1ns / 1ps
// Front end: accepts packet bytes, tracks position, checksum and header,
// and builds a record for each word with a payload byte and/or the verdict. Uses swr_pkg.
module swr_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic [7:0]       data_byte,
   input  logic             end_of_packet,
   output logic             rec_push,
   output swr_pkg::rec_type rec_data
);
   import swr_pkg::*;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       sum_ff, sum_in;
   logic [7:0]       hdr_ff [HDR_W];
   logic [7:0]       hdr_in [HDR_W];
   logic [7:0]       last_hi_ff, last_hi_in;
   logic [7:0]       last_lo_ff, last_lo_in;
   logic             done_ff, done_in;

   logic             in_range, in_hdr, take;
   logic [13:0]      plen;
   logic [POS_W-1:0] limit;
   logic [8:0]       sum_t;
   logic [7:0]       sum_add, sum_upd;
   logic [7:0]       hdr_upd [HDR_W];
   logic             is_ack, in_order, good, last_flag;
   logic signed [8:0] lh, ll, nh, nl;
   logic             live;

   // Position and payload window
   always_comb begin
      in_range = pos_ff < POS_W'(MAX_PACKET_BYTES);
      in_hdr   = pos_ff < POS_W'(HEADER_BYTES);
      plen     = {hdr_ff[HDR_LEN_HI][6:0], hdr_ff[HDR_LEN_LO][6:0]};
      limit    = {1'b0, plen} + POS_W'(HEADER_BYTES);
      take     = in_range && (in_hdr || (pos_ff < limit));
   end

   // End-around-carry sum and header capture, with this word included
   always_comb begin
      sum_t   = {1'b0, sum_ff} + {1'b0, data_byte};
      sum_add = sum_t[7:0] + {7'd0, sum_t[8]};
      sum_upd = take ? sum_add : sum_ff;
      for (int i = 0; i < HDR_W; i++) begin
         hdr_upd[i] = (take && in_hdr && (pos_ff == POS_W'(i + 1))) ? data_byte : hdr_ff[i];
      end
   end

   // Verdict: type check, sequence order (signed bytes), checksum
   always_comb begin
      lh = {last_hi_ff[7], last_hi_ff};
      ll = {last_lo_ff[7], last_lo_ff};
      nh = {hdr_upd[HDR_SEQ_HI][7], hdr_upd[HDR_SEQ_HI]};
      nl = {hdr_upd[HDR_SEQ_LO][7], hdr_upd[HDR_SEQ_LO]};
      in_order  = ((lh == nh) && ((ll + 9'sd1) == nl)) ||
                  (((lh + 9'sd1) == nh) && (nl == 9'sd0) && (ll == 9'sd127));
      is_ack    = hdr_upd[HDR_TYPE] == CODE_ACK;
      good      = is_ack && in_order && (sum_upd == SUM_GOOD);
      last_flag = hdr_upd[HDR_LAST] == LAST_MARK;
   end

   // Record for the back end
   always_comb begin
      live = accept && !done_ff;
      rec_data.has_payload   = take && !in_hdr;
      rec_data.payload_byte  = data_byte;
      rec_data.has_verdict   = end_of_packet;
      rec_data.reply_code    = is_ack ? CODE_ACK : CODE_NAK;
      rec_data.reply_seq_high = (!is_ack || good) ? hdr_upd[HDR_SEQ_HI] : SEQ_REJECT;
      rec_data.reply_seq_low  = (!is_ack || good) ? hdr_upd[HDR_SEQ_LO] : SEQ_REJECT;
      rec_data.accepted      = good;
      rec_data.transfer_done = good && last_flag;
      rec_push = live && (rec_data.has_payload || end_of_packet);
   end

   // Next state
   always_comb begin
      pos_in     = pos_ff;
      sum_in     = sum_ff;
      hdr_in     = hdr_ff;
      last_hi_in = last_hi_ff;
      last_lo_in = last_lo_ff;
      done_in    = done_ff;
      if (live) begin
         pos_in = in_range ? (pos_ff + POS_W'(1)) : pos_ff;
         sum_in = sum_upd;
         hdr_in = hdr_upd;
         if (end_of_packet) begin
            pos_in = '0;
            sum_in = '0;
            for (int i = 0; i < HDR_W; i++) begin
               hdr_in[i] = '0;
            end
            if (good) begin
               last_hi_in = hdr_upd[HDR_SEQ_HI];
               last_lo_in = hdr_upd[HDR_SEQ_LO];
               done_in    = last_flag;
            end
         end
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         sum_ff     <= '0;
         for (int i = 0; i < HDR_W; i++) begin
            hdr_ff[i] <= '0;
         end
         last_hi_ff <= '0;
         last_lo_ff <= LAST_LO_RESET;
         done_ff    <= 1'b0;
      end else begin
         pos_ff     <= pos_in;
         sum_ff     <= sum_in;
         hdr_ff     <= hdr_in;
         last_hi_ff <= last_hi_in;
         last_lo_ff <= last_lo_in;
         done_ff    <= done_in;
      end
   end

endmodule

FILE: rtl/swr_queue.sv
`timescale 1ns / 1ps
// Short record queue between front and back ends.
// Uses swr_pkg for the record type and depth.
module swr_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  swr_pkg::rec_type push_data,
   input  logic             pop,
   output swr_pkg::rec_type head,
   output logic             empty,
   output logic             full
);
   import swr_pkg::*;

   rec_type            mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ff, wr_in;
   logic [QPTR_W-1:0]  rd_ff, rd_in;
   logic [QCNT_W-1:0]  cnt_ff, cnt_in;
   logic               do_push, do_pop;

   // Flags and head word
   always_comb begin
      empty   = cnt_ff == '0;
      full    = cnt_ff == QCNT_W'(QUEUE_DEPTH);
      head    = mem_ff[rd_ff];
      do_push = push && !full;
      do_pop  = pop && !empty;
      wr_in   = do_push ? (wr_ff + QPTR_W'(1)) : wr_ff;
      rd_in   = do_pop ? (rd_ff + QPTR_W'(1)) : rd_ff;
      cnt_in  = cnt_ff + QCNT_W'(do_push) - QCNT_W'(do_pop);
   end

   // Pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/swr_back.sv
`timescale 1ns / 1ps
// Back end: expands each queued record into a payload word and/or a verdict
// word, held in an output register. Uses swr_pkg.
module swr_back (
   input  logic             clock,
   input  logic             reset,
   input  swr_pkg::rec_type head,
   input  logic             q_empty,
   output logic             q_pop,
   input  logic             out_pop,
   output logic             out_valid,
   output logic             item_type,
   output logic [7:0]       payload_byte,
   output logic [7:0]       reply_code,
   output logic [7:0]       reply_seq_high,
   output logic [7:0]       reply_seq_low,
   output logic             accepted,
   output logic             transfer_done,
   output logic             final_item
);
   import swr_pkg::*;

   logic       vld_ff, vld_in;
   logic       phase_ff, phase_in;   // payload of head already sent
   logic       load, emit_pay;
   logic       type_ff, type_in;
   logic [7:0] pay_ff, pay_in, code_ff, code_in, shi_ff, shi_in, slo_ff, slo_in;
   logic       acc_ff, acc_in, done_ff, done_in, fin_ff, fin_in;

   // Pick the next word from the queue head
   always_comb begin
      load     = !q_empty && (!vld_ff || out_pop);
      emit_pay = !phase_ff && head.has_payload;
      q_pop    = load && !(emit_pay && head.has_verdict);
      vld_in   = load || (vld_ff && !out_pop);
      phase_in = phase_ff;
      type_in  = type_ff;
      pay_in   = pay_ff;
      code_in  = code_ff;
      shi_in   = shi_ff;
      slo_in   = slo_ff;
      acc_in   = acc_ff;
      done_in  = done_ff;
      fin_in   = fin_ff;
      if (load) begin
         if (emit_pay) begin
            type_in  = ITEM_PAYLOAD;
            pay_in   = head.payload_byte;
            code_in  = '0;
            shi_in   = '0;
            slo_in   = '0;
            acc_in   = 1'b0;
            done_in  = 1'b0;
            fin_in   = !head.has_verdict;
            phase_in = head.has_verdict;
         end else begin
            type_in  = ITEM_VERDICT;
            pay_in   = '0;
            code_in  = head.reply_code;
            shi_in   = head.reply_seq_high;
            slo_in   = head.reply_seq_low;
            acc_in   = head.accepted;
            done_in  = head.transfer_done;
            fin_in   = 1'b1;
            phase_in = 1'b0;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff   <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         vld_ff   <= vld_in;
         phase_ff <= phase_in;
      end
   end

   // Output word register
   always_ff @(posedge clock) begin
      type_ff <= type_in;
      pay_ff  <= pay_in;
      code_ff <= code_in;
      shi_ff  <= shi_in;
      slo_ff  <= slo_in;
      acc_ff  <= acc_in;
      done_ff <= done_in;
      fin_ff  <= fin_in;
   end

   assign out_valid      = vld_ff;
   assign item_type      = type_ff;
   assign payload_byte   = pay_ff;
   assign reply_code     = code_ff;
   assign reply_seq_high = shi_ff;
   assign reply_seq_low  = slo_ff;
   assign accepted       = acc_ff;
   assign transfer_done  = done_ff;
   assign final_item     = fin_ff;

endmodule

FILE: rtl/stop_wait_packet_receiver_unit.sv
`timescale 1ns / 1ps
// Stop-and-wait packet receiver, top level. Uses swr_pkg, swr_front,
// swr_queue and swr_back.
//
// Input words (req_data_byte, req_end_of_packet) are taken at an edge with
// req_push high and req_full low, one packet byte per word, header first.
// Result words come out queue-style: while rsp_empty is low the oldest word
// is on the rsp_ ports, and it leaves at an edge with rsp_pop high.
// A payload byte yields one word; the end-of-packet byte yields its verdict
// word, preceded by a payload word if that byte is payload too.
// Path: a word's record enters the queue at the edge that takes it; its first
// result is then loaded from the queue head into the output register at a
// later edge, after which it is on the rsp_ ports and can be popped.
// Throughput: one input word per cycle while req_full is low and one result
// word per cycle while rsp_pop is high, as the output register emits one word
// a cycle; the 4-entry record queue absorbs two-result words holding it up.
// Reset clears the packet state, the stored sequence (to minus one) and the
// transfer-done flag; the block is ready in the cycle after reset.
// When the receiver stops popping, the queue fills and req_full rises;
// nothing is dropped. Once the transfer is done, words are still taken but
// give no result.
module stop_wait_packet_receiver_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_data_byte,
   input  logic       req_end_of_packet,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic       rsp_item_type,
   output logic [7:0] rsp_payload_byte,
   output logic [7:0] rsp_reply_code,
   output logic [7:0] rsp_reply_seq_high,
   output logic [7:0] rsp_reply_seq_low,
   output logic       rsp_accepted,
   output logic       rsp_transfer_done,
   output logic       rsp_final_item
);
   import swr_pkg::*;

   logic    accept;
   logic    rec_push;
   rec_type rec_data;
   rec_type q_head;
   logic    q_empty, q_full, q_pop;
   logic    out_valid;

   assign req_full  = q_full;
   assign accept    = req_push && !q_full;
   assign rsp_empty = !out_valid;

   // Front: classify bytes and build records
   swr_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .data_byte     (req_data_byte),
      .end_of_packet (req_end_of_packet),
      .rec_push      (rec_push),
      .rec_data      (rec_data)
   );

   // Record queue
   swr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rec_push),
      .push_data (rec_data),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty),
      .full      (q_full)
   );

   // Back: emit result words
   swr_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (q_head),
      .q_empty        (q_empty),
      .q_pop          (q_pop),
      .out_pop        (rsp_pop),
      .out_valid      (out_valid),
      .item_type      (rsp_item_type),
      .payload_byte   (rsp_payload_byte),
      .reply_code     (rsp_reply_code),
      .reply_seq_high (rsp_reply_seq_high),
      .reply_seq_low  (rsp_reply_seq_low),
      .accepted       (rsp_accepted),
      .transfer_done  (rsp_transfer_done),
      .final_item     (rsp_final_item)
   );

endmodule

FILE: tb/sv/stop_wait_packet_receiver_unit_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the stop-and-wait packet receiver: watches both channels,
// predicts the result words of every taken word and compares them in order.
// Depends on swr_pkg for framing constants, reply codes and word kinds.
module stop_wait_packet_receiver_unit_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  logic       req_full,
   input  logic [7:0] req_data_byte,
   input  logic       req_end_of_packet,
   input  logic       rsp_empty,
   input  logic       rsp_pop,
   input  logic       rsp_item_type,
   input  logic [7:0] rsp_payload_byte,
   input  logic [7:0] rsp_reply_code,
   input  logic [7:0] rsp_reply_seq_high,
   input  logic [7:0] rsp_reply_seq_low,
   input  logic       rsp_accepted,
   input  logic       rsp_transfer_done,
   input  logic       rsp_final_item,
   output int         mismatch_count,
   output int         results_owed
);
   import swr_pkg::*;

   // Field order matches the concatenation of the rsp_ ports below
   typedef struct packed {
      logic       item_type;
      logic [7:0] payload_byte;
      logic [7:0] reply_code;
      logic [7:0] reply_seq_high;
      logic [7:0] reply_seq_low;
      logic       accepted;
      logic       transfer_done;
      logic       final_item;
   } rsp_word_type;

   // Receiver state as the block should hold it
   int         pkt_pos;
   logic [7:0] pkt_sum;
   logic [7:0] hdr [HDR_W];
   logic [7:0] kept_seq_hi;
   logic [7:0] kept_seq_lo;
   logic       transfer_over;

   rsp_word_type owed_words [$];
   int           words_checked;

   initial begin
      mismatch_count = 0;
      results_owed   = 0;
      words_checked  = 0;
   end

   // Printing stops after the first hundred, counting does not
   task automatic report(input string what);
      if (mismatch_count < 100)
         $display("swr check: result word %0d at %0t ns: %s", words_checked, $time, what);
      mismatch_count++;
   endtask

   task automatic clear_packet();
      pkt_pos = 0;
      pkt_sum = 8'h00;
      foreach (hdr[i]) hdr[i] = 8'h00;
   endtask

   // One taken word: header capture, end-around-carry sum, payload and verdict
   task automatic absorb_byte(input logic [7:0] b, input logic eop);
      rsp_word_type made [$];
      rsp_word_type w;
      logic [8:0]   t9;
      logic [7:0]   sh, sl;
      int           plen, lh, ll, nh, nl;
      bit           in_order;
      if (transfer_over) return;
      if (pkt_pos < MAX_PACKET_BYTES) begin
         plen = int'(hdr[HDR_LEN_HI][6:0]) * 128 + int'(hdr[HDR_LEN_LO][6:0]);
         if (pkt_pos < HEADER_BYTES || pkt_pos < plen + HEADER_BYTES) begin
            t9 = {1'b0, pkt_sum} + {1'b0, b};
            pkt_sum = t9[7:0] + t9[8];
            if (pkt_pos < HEADER_BYTES) begin
               if (pkt_pos >= 1) hdr[pkt_pos - 1] = b;
            end else begin
               w = '0;
               w.item_type = ITEM_PAYLOAD;
               w.payload_byte = b;
               made.push_back(w);
            end
         end
         pkt_pos++;
      end
      if (eop) begin
         sh = hdr[HDR_SEQ_HI];
         sl = hdr[HDR_SEQ_LO];
         w = '0;
         w.item_type = ITEM_VERDICT;
         if (hdr[HDR_TYPE] != CODE_ACK) begin
            w.reply_code = CODE_NAK;
            w.reply_seq_high = sh;
            w.reply_seq_low = sl;
         end else begin
            // sequence bytes compare as signed 8-bit values
            lh = int'($signed(kept_seq_hi));
            ll = int'($signed(kept_seq_lo));
            nh = int'($signed(sh));
            nl = int'($signed(sl));
            in_order = (lh == nh && ll + 1 == nl) || (lh + 1 == nh && nl == 0 && ll == 127);
            w.reply_code = CODE_ACK;
            if (in_order && pkt_sum == SUM_GOOD) begin
               kept_seq_hi = sh;
               kept_seq_lo = sl;
               w.reply_seq_high = sh;
               w.reply_seq_low = sl;
               w.accepted = 1'b1;
               if (hdr[HDR_LAST] == LAST_MARK) transfer_over = 1'b1;
            end else begin
               w.reply_seq_high = SEQ_REJECT;
               w.reply_seq_low = SEQ_REJECT;
            end
         end
         w.transfer_done = transfer_over;
         made.push_back(w);
         clear_packet();
      end
      if (made.size() > 0) made[made.size() - 1].final_item = 1'b1;
      foreach (made[i]) owed_words.push_back(made[i]);
   endtask

   task automatic compare_field(input string name, input logic [7:0] got, input logic [7:0] want);
      if (got !== want) report($sformatf("%s is %0h, expected %0h", name, got, want));
   endtask

   task automatic check_word();
      rsp_word_type seen, want;
      seen = {rsp_item_type, rsp_payload_byte, rsp_reply_code, rsp_reply_seq_high,
              rsp_reply_seq_low, rsp_accepted, rsp_transfer_done, rsp_final_item};
      if (owed_words.size() == 0) begin
         report("result word with nothing expected");
      end else begin
         want = owed_words.pop_front();
         compare_field("item_type", 8'(seen.item_type), 8'(want.item_type));
         compare_field("payload_byte", seen.payload_byte, want.payload_byte);
         compare_field("reply_code", seen.reply_code, want.reply_code);
         compare_field("reply_seq_high", seen.reply_seq_high, want.reply_seq_high);
         compare_field("reply_seq_low", seen.reply_seq_low, want.reply_seq_low);
         compare_field("accepted", 8'(seen.accepted), 8'(want.accepted));
         compare_field("transfer_done", 8'(seen.transfer_done), 8'(want.transfer_done));
         compare_field("final_item", 8'(seen.final_item), 8'(want.final_item));
      end
      words_checked++;
   endtask

   // Results leave before the word taken at the same edge is predicted
   always @(posedge clock) begin
      if (reset) begin
         clear_packet();
         kept_seq_hi = 8'h00;
         kept_seq_lo = LAST_LO_RESET;
         transfer_over = 1'b0;
         owed_words.delete();
      end else begin
         if (rsp_pop && !rsp_empty) check_word();
         if (req_push && !req_full) absorb_byte(req_data_byte, req_end_of_packet);
      end
      results_owed = owed_words.size();
   end

endmodule

FILE: tb/sv/stop_wait_packet_receiver_unit_test.sv
`timescale 1ns / 1ps
// Top of the receiver test: clock, reset, packet stimulus and the verdict.
// Depends on swr_pkg, stop_wait_packet_receiver_unit and its checker.
module stop_wait_packet_receiver_unit_test;
   import swr_pkg::*;

   localparam int LONG_STALL  = 150;
   localparam int PHASE_WORDS = 180;

   logic       clock;
   logic       reset;
   logic       req_push;
   logic       req_full;
   logic [7:0] req_data_byte;
   logic       req_end_of_packet;
   logic       rsp_empty;
   logic       rsp_pop;
   logic       rsp_item_type;
   logic [7:0] rsp_payload_byte;
   logic [7:0] rsp_reply_code;
   logic [7:0] rsp_reply_seq_high;
   logic [7:0] rsp_reply_seq_low;
   logic       rsp_accepted;
   logic       rsp_transfer_done;
   logic       rsp_final_item;

   int         mismatch_count;
   int         results_owed;

   // Idle rates in percent; written at rising edges, read at falling ones
   int         tx_idle_pct;
   int         rx_idle_pct;
   bit         long_stall_req;

   // Last sequence the block should have stored, tracked to build in-order packets
   logic [7:0] seq_hi_done;
   logic [7:0] seq_lo_done;

   stop_wait_packet_receiver_unit i_dut (.*);

   stop_wait_packet_receiver_unit_checker i_check (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1000000;
      $display("tb: failure");
      $finish;
   end

   // Receiver side: random pops, plus one long hold-off when asked for
   initial begin : receiver
      int stall_left;
      bit stall_done;
      stall_done = 1'b0;
      rsp_pop = 1'b0;
      forever begin
         @(negedge clock);
         if (long_stall_req && !stall_done) begin
            rsp_pop <= 1'b0;
            stall_done = 1'b1;
            for (stall_left = LONG_STALL; stall_left > 1; stall_left--) @(negedge clock);
         end else begin
            rsp_pop <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   function automatic logic [15:0] next_in_order();
      if (seq_lo_done == 8'h7F) return {seq_hi_done + 8'd1, 8'h00};
      return {seq_hi_done, seq_lo_done + 8'd1};
   endfunction

   // Entered and left at a falling edge; push stays high between back-to-back words
   task automatic send_word(input logic [7:0] d, input logic eop);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push <= 1'b1;
      req_data_byte <= d;
      req_end_of_packet <= eop;
      do @(posedge clock); while (req_full);
      @(negedge clock);
   endtask

   // Builds a packet with a checksum that is good over the summed bytes,
   // sends the first n_sent bytes and closes the packet on the last one
   task automatic send_packet(input logic [7:0] last_flag, input logic [7:0] seq_hi,
                              input logic [7:0] seq_lo, input logic [7:0] pkt_type,
                              input int len, input int n_sent, input bit corrupt);
      logic [7:0]  pkt [$];
      logic [13:0] len_bits;
      logic [8:0]  t9;
      logic [7:0]  fold;
      int          limit, i;
      len_bits = len[13:0];
      pkt.push_back(8'h00);
      pkt.push_back(last_flag);
      pkt.push_back(seq_hi);
      pkt.push_back(seq_lo);
      // top bits of the length bytes are masked off by the block
      pkt.push_back({1'($urandom_range(1)), len_bits[13:7]});
      pkt.push_back({1'($urandom_range(1)), len_bits[6:0]});
      pkt.push_back(pkt_type);
      while (pkt.size() < n_sent) pkt.push_back(8'($urandom_range(255)));
      limit = n_sent;
      if (len + HEADER_BYTES < limit) limit = len + HEADER_BYTES;
      if (MAX_PACKET_BYTES < limit) limit = MAX_PACKET_BYTES;
      fold = 8'h00;
      for (i = 1; i < limit; i++) begin
         t9 = {1'b0, fold} + {1'b0, pkt[i]};
         fold = t9[7:0] + t9[8];
      end
      pkt[0] = SUM_GOOD - fold;
      // never FF, so a corrupted checksum really breaks the sum
      if (corrupt) pkt[0] = pkt[0] ^ 8'($urandom_range(254, 1));
      for (i = 0; i < n_sent; i++) send_word(pkt[i], i == n_sent - 1);
      if (pkt_type == CODE_ACK && !corrupt && n_sent >= HEADER_BYTES &&
          {seq_hi, seq_lo} == next_in_order()) begin
         seq_hi_done = seq_hi;
         seq_lo_done = seq_lo;
      end
   endtask

   // Mostly good in-order packets, the rest broken in one way each
   task automatic random_packet(output int n_words);
      int          kind, len, n_sent, i;
      logic [15:0] seq;
      logic [7:0]  last_flag, pkt_type;
      bit          corrupt;
      kind = $urandom_range(99);
      len = ($urandom_range(9) == 0) ? $urandom_range(200, 40) : $urandom_range(8);
      seq = next_in_order();
      last_flag = 8'($urandom_range(255));
      if (last_flag == LAST_MARK) last_flag = 8'h00;
      pkt_type = CODE_ACK;
      n_sent = len + HEADER_BYTES;
      corrupt = 1'b0;
      if (kind >= 95) begin
         // line noise, closed by an end mark so the next packet starts clean
         n_words = $urandom_range(12, 1);
         for (i = 1; i <= n_words; i++)
            send_word(8'($urandom_range(255)), i == n_words || $urandom_range(7) == 0);
         return;
      end
      // the last mark is harmless on packets that get rejected
      if (kind >= 55 && kind < 80 && $urandom_range(3) == 0) last_flag = LAST_MARK;
      if (kind >= 55 && kind < 65) begin
         corrupt = 1'b1;
      end else if (kind >= 65 && kind < 72) begin
         do pkt_type = 8'($urandom_range(255)); while (pkt_type == CODE_ACK);
      end else if (kind >= 72 && kind < 80) begin
         seq = 16'($urandom_range(16'hFFFF));
         if (seq == next_in_order()) seq[6] = ~seq[6];
      end else if (kind >= 80 && kind < 88) begin
         n_sent = $urandom_range(len + HEADER_BYTES - 1, 1);
      end else if (kind >= 88) begin
         n_sent += $urandom_range(6, 1);
      end
      send_packet(last_flag, seq[15:8], seq[7:0], pkt_type, len, n_sent, corrupt);
      n_words = n_sent;
   endtask

   // Sender pauses until every owed result word has come, then retunes the idling
   task automatic settle(input int tx_pct, input int rx_pct, input bit stall_rx);
      req_push <= 1'b0;
      do @(negedge clock); while (results_owed != 0);
      @(posedge clock);
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      long_stall_req = stall_rx;
      @(negedge clock);
   endtask

   initial begin : stimulus
      int          tx_plan [3];
      int          rx_plan [3];
      int          phase, words, n, waited;
      logic [15:0] seq;
      tx_plan = '{20, 69, 0};
      rx_plan = '{69, 20, 0};
      reset = 1'b1;
      req_push = 1'b0;
      req_data_byte = 8'h00;
      req_end_of_packet = 1'b0;
      tx_idle_pct = tx_plan[0];
      rx_idle_pct = rx_plan[0];
      long_stall_req = 1'b0;
      seq_hi_done = 8'h00;
      seq_lo_done = LAST_LO_RESET;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: first in-order packet, one-byte packet, header cut short,
      // excess bytes past the length, NAK type carrying the last mark
      send_packet(8'h00, 8'h00, 8'h00, CODE_ACK, 2, 9, 1'b0);
      send_packet(8'h00, 8'h00, 8'h00, CODE_ACK, 0, 1, 1'b0);
      send_packet(8'hFF, 8'h80, 8'hFF, CODE_ACK, 5, 3, 1'b0);
      send_packet(8'h01, 8'h00, 8'h01, CODE_ACK, 1, 10, 1'b0);
      send_packet(LAST_MARK, 8'h00, 8'h02, CODE_NAK, 0, 7, 1'b0);

      // Random phases; the first one opens with the long receiver hold-off
      for (phase = 0; phase < 3; phase++) begin
         settle(tx_plan[phase], rx_plan[phase], phase == 0);
         words = 0;
         while (words < PHASE_WORDS) begin
            random_packet(n);
            words += n;
         end
      end

      // Last packet of the transfer; everything after it is ignored
      seq = next_in_order();
      send_packet(LAST_MARK, seq[15:8], seq[7:0], CODE_ACK, 3, 10, 1'b0);
      repeat (8) send_word(8'($urandom_range(255)), 1'($urandom_range(1)));

      req_push <= 1'b0;
      waited = 0;
      do begin
         @(negedge clock);
         waited++;
      end while (results_owed != 0 && waited < 50000);
      repeat (8) @(negedge clock);
      if (results_owed != 0) $display("swr tb: %0d result words never arrived", results_owed);
      if (mismatch_count == 0 && results_owed == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
